FILE: src/nmst_pkg.sv
// ----------------------------------------------------------------------------
// nmst_pkg
// Types, codes and helpers shared by the named mailbox slot table.
// ----------------------------------------------------------------------------
package nmst_pkg;

  localparam int unsigned FieldW     = 56;
  localparam int unsigned FieldChars = FieldW / 8;

  typedef logic [FieldW-1:0] field_t;

  typedef enum logic {
    FUNC_SEND = 1'b0,
    FUNC_RECV = 1'b1
  } func_e;

  typedef enum logic {
    STATUS_OK   = 1'b0,
    STATUS_FAIL = 1'b1
  } status_e;

  typedef struct packed {
    logic   func;
    field_t sender_id;
    field_t dest_id;
    field_t payload;
  } req_t;

  typedef struct packed {
    logic   status;
    field_t got_sender;
    field_t got_payload;
  } rsp_t;

  typedef struct packed {
    field_t sender;
    field_t dest;
    field_t text;
  } slot_t;

  localparam int unsigned SlotW = $bits(slot_t);

  // keep at most n characters up to the first nul, zero the rest
  function automatic field_t cut_text(field_t v, int unsigned n);
    field_t r;
    logic   stop;
    r    = '0;
    stop = 1'b0;
    for (int unsigned i = 0; i < FieldChars; i++) begin
      if (v[8*i +: 8] == 8'h00) begin
        stop = 1'b1;
      end
      if (!stop && (i < n)) begin
        r[8*i +: 8] = v[8*i +: 8];
      end
    end
    return r;
  endfunction

endpackage

FILE: src/nmst_ram.sv
// ----------------------------------------------------------------------------
// nmst_ram
// Generic single-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module nmst_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 8,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] addr_i,
  input  logic [Width-1:0] wdata_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/nmst_free_enc.sv
// ----------------------------------------------------------------------------
// nmst_free_enc
// Finds the lowest free slot from the used marks.
// ----------------------------------------------------------------------------
module nmst_free_enc #(
  parameter int unsigned SlotCount = 8,
  parameter int unsigned IdxW      = (SlotCount > 1) ? $clog2(SlotCount) : 1
) (
  input  logic [SlotCount-1:0] used_i,
  output logic                 found_o,
  output logic [IdxW-1:0]      idx_o
);

  always_comb begin
    found_o = 1'b0;
    idx_o   = '0;
    for (int i = SlotCount - 1; i >= 0; i--) begin
      if (!used_i[i]) begin
        found_o = 1'b1;
        idx_o   = IdxW'(i);
      end
    end
  end

endmodule

FILE: src/named_mailbox_slot_table.sv
// ----------------------------------------------------------------------------
// named_mailbox_slot_table
// Message slot table: send stores a message in the lowest free slot, receive
// returns and frees the lowest used slot addressed to the given name.
// ----------------------------------------------------------------------------
//   channel   direction   handshake                  payload
//   in        request     in_valid_i / in_stall_o    in_req_i  (nmst_pkg::req_t)
//   out       result      out_valid_o / out_stall_i  out_rsp_o (nmst_pkg::rsp_t)
//
// send goes from acceptance to result in order: pick and write, result, output.
// receive scans the slots from the lowest, one slot RAM read per cycle.
// used marks live in flops and clear on reset; slot data needs no clearing.
// one request is in flight at a time; a held result stalls only completion.
// ----------------------------------------------------------------------------
module named_mailbox_slot_table #(
  parameter int unsigned SLOT_COUNT = 8,
  parameter int unsigned NAME_CHARS = 7,
  parameter int unsigned TEXT_CHARS = 7
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  nmst_pkg::req_t  in_req_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output nmst_pkg::rsp_t  out_rsp_o
);

  import nmst_pkg::*;

  localparam int unsigned IdxW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(SLOT_COUNT - 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEND,
    ST_SCAN,
    ST_DONE
  } state_e;

  state_e              state_q;
  logic [SLOT_COUNT-1:0] used_q;
  logic [IdxW-1:0]     idx_q;
  req_t                req_q;
  rsp_t                res_q;
  rsp_t                out_rsp_q;
  logic                out_valid_q;

  logic                free_found;
  logic [IdxW-1:0]     free_idx;
  logic                ram_we;
  logic [IdxW-1:0]     ram_addr;
  slot_t               ram_wdata;
  slot_t               ram_rdata;
  logic                hit;
  logic                out_load;

  nmst_free_enc #(
    .SlotCount (SLOT_COUNT),
    .IdxW      (IdxW)
  ) u_free_enc (
    .used_i  (used_q),
    .found_o (free_found),
    .idx_o   (free_idx)
  );

  nmst_ram #(
    .Width (SlotW),
    .Depth (SLOT_COUNT),
    .AddrW (IdxW)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  assign ram_wdata = '{sender: req_q.sender_id, dest: req_q.dest_id, text: req_q.payload};
  assign hit       = used_q[idx_q] && (ram_rdata.dest == req_q.dest_id);
  assign out_load  = (state_q == ST_DONE) && (!out_valid_q || !out_stall_i);

  always_comb begin
    ram_we   = 1'b0;
    ram_addr = '0;
    case (state_q)
      ST_SEND: begin
        ram_we   = free_found;
        ram_addr = free_idx;
      end
      ST_SCAN: begin
        ram_addr = IdxW'(idx_q + 1'b1);
      end
      default: begin
        ram_addr = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      used_q      <= '0;
      idx_q       <= '0;
      req_q       <= '0;
      res_q       <= '0;
      out_rsp_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_load) begin
        out_rsp_q   <= res_q;
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            req_q.func <= in_req_i.func;
            idx_q      <= '0;
            if (in_req_i.func == FUNC_SEND) begin
              req_q.sender_id <= cut_text(in_req_i.sender_id, NAME_CHARS);
              req_q.dest_id   <= cut_text(in_req_i.dest_id, NAME_CHARS);
              req_q.payload   <= cut_text(in_req_i.payload, TEXT_CHARS);
              state_q         <= ST_SEND;
            end else begin
              req_q.sender_id <= '0;
              req_q.dest_id   <= cut_text(in_req_i.dest_id, FieldChars);
              req_q.payload   <= '0;
              state_q         <= ST_SCAN;
            end
          end
        end
        ST_SEND: begin
          res_q <= '{status: (free_found ? STATUS_OK : STATUS_FAIL),
                     got_sender: '0, got_payload: '0};
          if (free_found) begin
            used_q[free_idx] <= 1'b1;
          end
          state_q <= ST_DONE;
        end
        ST_SCAN: begin
          if (hit) begin
            used_q[idx_q] <= 1'b0;
            res_q   <= '{status: STATUS_OK, got_sender: ram_rdata.sender,
                         got_payload: ram_rdata.text};
            state_q <= ST_DONE;
          end else if (idx_q == LastIdx) begin
            res_q   <= '{status: STATUS_FAIL, got_sender: '0, got_payload: '0};
            state_q <= ST_DONE;
          end else begin
            idx_q <= IdxW'(idx_q + 1'b1);
          end
        end
        ST_DONE: begin
          if (out_load) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

endmodule

FILE: verif/named_mailbox_slot_table_tb.sv
// ----------------------------------------------------------------------------
// named_mailbox_slot_table_tb
// Drives send and receive requests into the mailbox slot table. The requests
// are a directed opening and then random phases built from a small pool of
// related names. A scoreboard keeps its own copy of the slot table, works out
// each response when its request is taken, and checks the responses in order.
// Both sides idle at random, and one long output stall backs up the input.
// ----------------------------------------------------------------------------
module named_mailbox_slot_table_tb;
  import nmst_pkg::*;

  localparam int unsigned Slots      = 8;
  localparam int unsigned NameChars  = 7;
  localparam int unsigned TextChars  = 7;
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned LongHold   = 200;
  localparam int unsigned DrainWait  = 16;

  typedef struct {
    req_t        req;
    int unsigned gap;
  } pending_t;

  logic clk        = 1'b0;
  logic rst_n      = 1'b0;
  logic in_valid   = 1'b0;
  logic in_stall;
  req_t in_req     = '0;
  logic out_valid;
  logic out_stall  = 1'b0;
  rsp_t out_rsp;

  pending_t    pending_q[$];
  rsp_t        expected_rsp_q[$];
  int unsigned n_items     = 0;
  int unsigned n_accepted  = 0;
  int unsigned n_responses = 0;
  int unsigned n_errors    = 0;
  int unsigned n_cycles    = 0;
  int unsigned idle_count  = 0;
  int unsigned hold_left   = 0;
  bit          long_done   = 1'b0;

  // scoreboard copy of the slot table
  bit     mb_used [Slots];
  field_t mb_from [Slots];
  field_t mb_to   [Slots];
  field_t mb_text [Slots];

  field_t nm_empty, nm_x, nm_xy, nm_ab, nm_abc, nm_full, nm_other;
  field_t name_pool [6];

  named_mailbox_slot_table #(
    .SLOT_COUNT (Slots),
    .NAME_CHARS (NameChars),
    .TEXT_CHARS (TextChars)
  ) i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_req_i    (in_req),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_rsp_o   (out_rsp)
  );

  always #2 clk = ~clk;

  function automatic field_t trim_at_nul(field_t v, int unsigned keep);
    field_t r;
    r = '0;
    for (int unsigned i = 0; i < FieldChars; i++) begin
      if (i >= keep || v[8*i +: 8] == 8'h00) break;
      r[8*i +: 8] = v[8*i +: 8];
    end
    return r;
  endfunction

  function automatic rsp_t mailbox_apply(req_t r);
    rsp_t   rsp;
    field_t who;
    rsp = '0;
    rsp.status = STATUS_FAIL;
    if (r.func == FUNC_SEND) begin
      for (int i = 0; i < Slots; i++) begin
        if (!mb_used[i]) begin
          mb_from[i] = trim_at_nul(r.sender_id, NameChars);
          mb_to[i]   = trim_at_nul(r.dest_id, NameChars);
          mb_text[i] = trim_at_nul(r.payload, TextChars);
          mb_used[i] = 1'b1;
          rsp.status = STATUS_OK;
          break;
        end
      end
    end else begin
      who = trim_at_nul(r.dest_id, FieldChars);
      for (int i = 0; i < Slots; i++) begin
        if (mb_used[i] && mb_to[i] == who) begin
          rsp.got_sender  = mb_from[i];
          rsp.got_payload = mb_text[i];
          mb_used[i]      = 1'b0;
          rsp.status      = STATUS_OK;
          break;
        end
      end
    end
    return rsp;
  endfunction

  function automatic field_t rand_field();
    logic [63:0] w;
    w = {$urandom(), $urandom()};
    return w[FieldW-1:0];
  endfunction

  function automatic field_t make_name(int unsigned len);
    field_t v;
    v = '0;
    for (int unsigned i = 0; i < FieldChars; i++) begin
      if (i < len) v[8*i +: 8] = 8'($urandom_range(1, 255));
    end
    return v;
  endfunction

  // random junk above the terminating nul
  function automatic field_t dirty(field_t v);
    field_t r;
    bit     past;
    r    = v;
    past = 1'b0;
    for (int unsigned i = 0; i < FieldChars; i++) begin
      if (past) r[8*i +: 8] = 8'($urandom_range(0, 255));
      if (v[8*i +: 8] == 8'h00) past = 1'b1;
    end
    return r;
  endfunction

  function automatic field_t maybe_dirty(field_t v);
    return ($urandom_range(0, 1) != 0) ? dirty(v) : v;
  endfunction

  function automatic field_t make_text();
    return maybe_dirty(make_name($urandom_range(0, TextChars)));
  endfunction

  function automatic void push_item(func_e f, field_t s, field_t d, field_t p,
                                    int unsigned gap);
    pending_t e;
    e.req.func      = f;
    e.req.sender_id = s;
    e.req.dest_id   = d;
    e.req.payload   = p;
    e.gap           = gap;
    pending_q.push_back(e);
    n_items++;
  endfunction

  function automatic void push_send(field_t s, field_t d, field_t p);
    push_item(FUNC_SEND, s, d, p, $urandom_range(0, 3));
  endfunction

  function automatic void push_recv(field_t d, field_t junk);
    push_item(FUNC_RECV, junk, d, junk, $urandom_range(0, 3));
  endfunction

  function automatic void note_failure(string msg);
    n_errors++;
    if (n_errors <= 10) $display("ERROR: %s", msg);
  endfunction

  always @(posedge clk) begin : req_driver
    pending_t e;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        expected_rsp_q.push_back(mailbox_apply(in_req));
        n_accepted++;
      end
      if (!in_valid || !in_stall) begin
        if (pending_q.size() == 0) begin
          in_valid <= 1'b0;
        end else if (idle_count < pending_q[0].gap) begin
          idle_count++;
          in_valid <= 1'b0;
        end else begin
          e          = pending_q.pop_front();
          idle_count = 0;
          in_req   <= e.req;
          in_valid <= 1'b1;
        end
      end
    end
  end

  always @(posedge clk) begin : rsp_monitor
    rsp_t        want;
    bit          fire;
    int unsigned k;
    if (rst_n) begin
      fire = out_valid && !out_stall;
      if (fire) begin
        n_responses++;
        if (expected_rsp_q.size() == 0) begin
          note_failure($sformatf("response with no request pending: %p", out_rsp));
        end else begin
          want = expected_rsp_q.pop_front();
          if (out_rsp.status !== want.status)
            note_failure($sformatf("status: expected %0d, got %0d",
                                   want.status, out_rsp.status));
          if (out_rsp.got_sender !== want.got_sender)
            note_failure($sformatf("got_sender: expected %h, got %h",
                                   want.got_sender, out_rsp.got_sender));
          if (out_rsp.got_payload !== want.got_payload)
            note_failure($sformatf("got_payload: expected %h, got %h",
                                   want.got_payload, out_rsp.got_payload));
        end
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (!long_done && n_responses >= 300) begin
        // long back-pressure so the input side fills up
        long_done = 1'b1;
        hold_left = LongHold;
        out_stall <= 1'b1;
      end else if (fire) begin
        k = n_responses[6] ? 0 : $urandom_range(0, 3);
        hold_left = (k != 0) ? k - 1 : 0;
        out_stall <= (k != 0);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    n_cycles++;
    if (n_cycles >= CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    field_t      ones;
    int unsigned kind;
    int unsigned send_pct;
    int unsigned gap;
    bit          quiet;

    ones      = '1;
    nm_empty  = '0;
    nm_full   = make_name(NameChars);
    nm_ab     = trim_at_nul(nm_full, 2);
    nm_abc    = trim_at_nul(nm_full, 3);
    nm_x      = make_name(1);
    nm_xy     = nm_x;
    nm_xy[15:8] = 8'($urandom_range(1, 255));
    nm_other  = make_name(4);
    name_pool = '{nm_empty, nm_x, nm_ab, nm_abc, nm_full, nm_other};

    // directed: empty table, fill, full, exact-name matching, refill
    push_recv(ones, ones);
    push_send(ones, ones, ones);
    push_send('0, '0, '0);
    push_send(dirty(nm_x), dirty(nm_ab), dirty(make_name(3)));
    push_send(nm_full, nm_abc, make_text());
    push_send(nm_ab, nm_full, make_text());
    push_send(nm_abc, nm_x, ones);
    push_send(nm_other, nm_other, make_text());
    push_send(nm_x, nm_ab, make_name(TextChars));
    push_send(nm_full, nm_x, make_text());
    push_recv(dirty(nm_ab), ones);
    push_recv(nm_ab, '0);
    push_recv(nm_ab, ones);
    push_recv(nm_abc, '0);
    push_recv(nm_abc, ones);
    push_recv(nm_xy, '0);
    push_recv(nm_x, ones);
    push_recv(ones, '0);
    push_recv('0, ones);
    push_recv('0, '0);
    push_send(nm_full, nm_full, ones);
    push_recv(nm_full, '0);
    push_recv(nm_other, '0);
    push_recv(nm_full, '0);

    // random phases: fill-heavy, drain-heavy, balanced, and raw noise
    for (int b = 0; b < 30; b++) begin
      kind     = $urandom_range(0, 9);
      quiet    = (b % 4 == 1);
      send_pct = (kind < 4) ? 80 : (kind < 7) ? 20 : 50;
      for (int j = 0; j < 30; j++) begin
        gap = quiet ? 0 : $urandom_range(0, 3);
        if (kind == 0) begin
          push_item(func_e'($urandom_range(0, 1)), rand_field(), rand_field(),
                    rand_field(), gap);
        end else if ($urandom_range(0, 99) < send_pct) begin
          push_item(FUNC_SEND,
                    maybe_dirty(($urandom_range(0, 3) == 0) ?
                                make_name($urandom_range(0, NameChars)) :
                                name_pool[$urandom_range(0, 5)]),
                    maybe_dirty(name_pool[$urandom_range(0, 5)]),
                    ($urandom_range(0, 7) == 0) ? rand_field() : make_text(),
                    gap);
        end else begin
          push_item(FUNC_RECV, rand_field(),
                    maybe_dirty(name_pool[$urandom_range(0, 5)]),
                    rand_field(), gap);
        end
      end
    end

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    while (n_accepted != n_items) @(posedge clk);
    while (expected_rsp_q.size() != 0) @(posedge clk);
    repeat (DrainWait) @(posedge clk);

    if (n_errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

FILE: filelist.f
src/nmst_pkg.sv
src/nmst_ram.sv
src/nmst_free_enc.sv
src/named_mailbox_slot_table.sv
verif/named_mailbox_slot_table_tb.sv
